@@ rtl/core/ssr_pkg.sv @@
// Shared types, command codes and the color palette of the screen cell renderer.
package ssr_pkg;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_FRAME_START = 2'd0;
    localparam logic [1:0] CMD_CELL        = 2'd1;
    localparam logic [1:0] CMD_FRAME_END   = 2'd2;

    // Screen memory geometry.
    localparam int BMP_DEPTH  = 6144;
    localparam int ATTR_DEPTH = 768;
    localparam int BMP_AW     = 13;
    localparam int ATTR_AW    = 10;
    localparam logic [BMP_AW-1:0]  BMP_LIMIT = 13'd6144;
    localparam logic [ATTR_AW-1:0] ATTR_LAST = 10'd767;

    // Input beat.
    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] cell_offset;
        logic [7:0]  pixel_byte;
        logic [7:0]  attr_byte;
        logic        force_redraw;
        logic        ram_changed;
    } t_in_item;

    // Output beat.
    typedef struct packed {
        logic        redraw_due;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [3:0]  color_index;
        logic [15:0] color_rgb565;
        logic        is_pixel;
        logic        last;
    } t_out_item;

    // Work handed from the front end to the pixel back end.
    typedef struct packed {
        logic        is_pixel;
        logic        redraw_due;
        logic [4:0]  col;
        logic [7:0]  y;
        logic [7:0]  bits;
        logic [3:0]  ink;
        logic [3:0]  paper;
    } t_job;

    // Fixed sixteen-entry palette, upper half are the bright colors.
    function automatic logic [15:0] palette565(input logic [3:0] idx);
        logic [15:0] c;
        case (idx)
            4'd0:    c = 16'h0000;
            4'd1:    c = 16'h001E;
            4'd2:    c = 16'hF000;
            4'd3:    c = 16'hF01E;
            4'd4:    c = 16'h0780;
            4'd5:    c = 16'h079E;
            4'd6:    c = 16'hF780;
            4'd7:    c = 16'hF79E;
            4'd8:    c = 16'h0000;
            4'd9:    c = 16'h001F;
            4'd10:   c = 16'hF800;
            4'd11:   c = 16'hF81F;
            4'd12:   c = 16'h07E0;
            4'd13:   c = 16'h07FF;
            4'd14:   c = 16'hFFE0;
            default: c = 16'hFFFF;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/ssr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ssr_front.sv @@
// Front end: accepts beats, checks cells against the shadow stores, queues work.
module ssr_front #(
    parameter int FLASH_PERIOD = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ssr_pkg::t_in_item i_in_item,
    output logic             o_in_stall,
    input  logic             i_q_full,
    output logic             o_job_push,
    output ssr_pkg::t_job    o_job
);

    localparam int CW = $clog2(FLASH_PERIOD);
    localparam logic [CW-1:0] CNT_LAST = CW'(FLASH_PERIOD - 1);

    // Decision stage.
    logic                         r_s1_valid;
    ssr_pkg::t_in_item            r_s1_item;
    // Frame state.
    logic                         r_cache_valid;
    logic [CW-1:0]                r_flash_cnt;
    logic                         r_flash_inv;
    // Bypass of the newest bitmap write.
    logic                         r_fwd_valid;
    logic [ssr_pkg::BMP_AW-1:0]   r_fwd_addr;
    logic [7:0]                   r_fwd_data;
    // Attribute commit copy.
    logic                         r_sw_busy;
    logic [ssr_pkg::ATTR_AW-1:0]  r_sw_idx;
    logic                         r_sw_wr;
    logic [ssr_pkg::ATTR_AW-1:0]  r_sw_waddr;

    logic                         in_fire;
    logic                         in_cell_ok;
    logic [ssr_pkg::ATTR_AW-1:0]  in_ai;
    logic                         s1_fire;
    logic                         s1_start;
    logic                         s1_cell_ok;
    logic                         s1_end;
    logic [ssr_pkg::BMP_AW-1:0]   s1_off;
    logic [ssr_pkg::ATTR_AW-1:0]  s1_ai;
    logic [7:0]                   s1_y;
    logic [7:0]                   shadow_pix;
    logic                         skip;
    logic                         swap;
    logic [2:0]                   ink3;
    logic [2:0]                   paper3;
    logic [CW-1:0]                n_flash_cnt;
    logic                         cnt_wrap;
    logic [7:0]                   bmp_rdata;
    logic [7:0]                   cmt_rdata;
    logic [7:0]                   tf_rdata;
    logic                         bmp_we;
    logic                         tf_we;

    // Input side handshake; the copy pass and a waiting frame end hold input off.
    assign s1_fire   = r_s1_valid && !r_sw_busy && !r_sw_wr && !i_q_full;
    assign o_in_stall = r_sw_busy || r_sw_wr ||
                        (r_s1_valid && (!s1_fire || s1_end));
    assign in_fire   = i_in_valid && !o_in_stall;
    assign in_cell_ok = (i_in_item.command == ssr_pkg::CMD_CELL) &&
                        (i_in_item.cell_offset < ssr_pkg::BMP_LIMIT);
    assign in_ai     = {i_in_item.cell_offset[12:11], i_in_item.cell_offset[7:5],
                        i_in_item.cell_offset[4:0]};

    // Decode of the beat in the decision stage.
    assign s1_off     = r_s1_item.cell_offset;
    assign s1_start   = r_s1_item.command == ssr_pkg::CMD_FRAME_START;
    assign s1_end     = r_s1_item.command == ssr_pkg::CMD_FRAME_END;
    assign s1_cell_ok = (r_s1_item.command == ssr_pkg::CMD_CELL) &&
                        (s1_off < ssr_pkg::BMP_LIMIT);
    assign s1_y       = {s1_off[12:11], s1_off[7:5], s1_off[10:8]};
    assign s1_ai      = {s1_off[12:11], s1_off[7:5], s1_off[4:0]};

    // Skip test against the shadow bitmap and the committed attributes.
    assign shadow_pix = (r_fwd_valid && r_fwd_addr == s1_off) ? r_fwd_data : bmp_rdata;
    assign skip = r_cache_valid && (r_s1_item.pixel_byte == shadow_pix) &&
                  (r_s1_item.attr_byte == cmt_rdata) &&
                  ((r_flash_cnt != '0) || !r_s1_item.attr_byte[7]);

    // Ink and paper, swapped while a flashing cell is inverted.
    assign swap   = r_s1_item.attr_byte[7] && r_flash_inv;
    assign ink3   = swap ? r_s1_item.attr_byte[5:3] : r_s1_item.attr_byte[2:0];
    assign paper3 = swap ? r_s1_item.attr_byte[2:0] : r_s1_item.attr_byte[5:3];

    // Flash counter step.
    assign cnt_wrap    = r_flash_cnt == CNT_LAST;
    assign n_flash_cnt = cnt_wrap ? '0 : r_flash_cnt + CW'(1);

    // Job for the back end.
    always_comb begin
        o_job            = '0;
        o_job.is_pixel   = !s1_start;
        o_job.redraw_due = s1_start && (r_s1_item.force_redraw || cnt_wrap ||
                                        r_s1_item.ram_changed);
        o_job.col        = s1_off[4:0];
        o_job.y          = s1_y;
        o_job.bits       = r_s1_item.pixel_byte;
        o_job.ink        = {r_s1_item.attr_byte[6], ink3};
        o_job.paper      = {r_s1_item.attr_byte[6], paper3};
        if (s1_start) begin
            o_job.col   = '0;
            o_job.y     = '0;
            o_job.bits  = '0;
            o_job.ink   = '0;
            o_job.paper = '0;
        end
    end

    assign o_job_push = s1_fire && (s1_start || (s1_cell_ok && !skip));
    assign bmp_we     = s1_fire && s1_cell_ok && !skip;
    assign tf_we      = s1_fire && s1_cell_ok;

    // Decision stage and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_cache_valid <= 1'b0;
            r_flash_cnt   <= '0;
            r_flash_inv   <= 1'b0;
            r_fwd_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && s1_start) begin
                r_flash_cnt <= n_flash_cnt;
                if (cnt_wrap) begin
                    r_flash_inv <= !r_flash_inv;
                end
                if (r_s1_item.force_redraw) begin
                    r_cache_valid <= 1'b0;
                end
            end
            if (s1_fire && s1_end) begin
                r_cache_valid <= 1'b1;
            end
            if (bmp_we) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    // Payload of the decision stage and the bypass.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_item;
        end
        if (bmp_we) begin
            r_fwd_addr <= s1_off;
            r_fwd_data <= r_s1_item.pixel_byte;
        end
    end

    // Commit copy: one attribute entry per cycle after a frame end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_busy <= 1'b0;
            r_sw_idx  <= '0;
            r_sw_wr   <= 1'b0;
        end else begin
            r_sw_wr <= r_sw_busy;
            if (s1_fire && s1_end) begin
                r_sw_busy <= 1'b1;
                r_sw_idx  <= '0;
            end else if (r_sw_busy) begin
                if (r_sw_idx == ssr_pkg::ATTR_LAST) begin
                    r_sw_busy <= 1'b0;
                end else begin
                    r_sw_idx <= r_sw_idx + ssr_pkg::ATTR_AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_waddr <= r_sw_idx;
    end

    // Shadow bitmap.
    ssr_ram #(.WIDTH(8), .DEPTH(ssr_pkg::BMP_DEPTH)) u_bmp (
        .i_clk   (i_clk),
        .i_we    (bmp_we),
        .i_waddr (s1_off),
        .i_wdata (r_s1_item.pixel_byte),
        .i_re    (in_fire && in_cell_ok),
        .i_raddr (i_in_item.cell_offset),
        .o_rdata (bmp_rdata)
    );

    // Committed attributes.
    ssr_ram #(.WIDTH(8), .DEPTH(ssr_pkg::ATTR_DEPTH)) u_cmt (
        .i_clk   (i_clk),
        .i_we    (r_sw_wr),
        .i_waddr (r_sw_waddr),
        .i_wdata (tf_rdata),
        .i_re    (in_fire && in_cell_ok),
        .i_raddr (in_ai),
        .o_rdata (cmt_rdata)
    );

    // Attributes seen during the current frame.
    ssr_ram #(.WIDTH(8), .DEPTH(ssr_pkg::ATTR_DEPTH)) u_tf (
        .i_clk   (i_clk),
        .i_we    (tf_we),
        .i_waddr (s1_ai),
        .i_wdata (r_s1_item.attr_byte),
        .i_re    (r_sw_busy),
        .i_raddr (r_sw_idx),
        .o_rdata (tf_rdata)
    );

endmodule

@@ rtl/core/ssr_queue.sv @@
// Small job queue between the front end and the pixel back end.
module ssr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ssr_pkg::t_job o_job
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    ssr_pkg::t_job r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = r_count == NW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ rtl/core/ssr_back.sv @@
// Back end: expands queued jobs into output beats, one pixel per cycle while the output is not stalled.
module ssr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  ssr_pkg::t_job      i_q_job,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output ssr_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic               r_out_valid;
    ssr_pkg::t_out_item r_out_item;
    logic [2:0]         r_beat;
    logic               load;
    logic               bit_on;
    logic [3:0]         ci;
    ssr_pkg::t_out_item n_item;

    assign load   = i_q_valid && (!r_out_valid || !i_out_stall);
    assign bit_on = i_q_job.bits[3'd7 - r_beat];
    assign ci     = bit_on ? i_q_job.ink : i_q_job.paper;
    assign o_q_pop = load && (!i_q_job.is_pixel || r_beat == 3'd7);

    // Output beat for the current position in the head job.
    always_comb begin
        n_item = '0;
        if (i_q_job.is_pixel) begin
            n_item.pixel_x      = {i_q_job.col, r_beat};
            n_item.pixel_y      = i_q_job.y;
            n_item.color_index  = ci;
            n_item.color_rgb565 = ssr_pkg::palette565(ci);
            n_item.is_pixel     = 1'b1;
            n_item.last         = r_beat == 3'd7;
        end else begin
            n_item.redraw_due = i_q_job.redraw_due;
            n_item.last       = 1'b1;
        end
    end

    // Output register and pixel position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_beat      <= '0;
        end else begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= i_q_valid;
            end
            if (load && i_q_job.is_pixel) begin
                r_beat <= r_beat + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= n_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/core/spectrum_screen_cell_renderer.sv @@
// Top level of the attribute-display cell renderer.
// A frame is fed as a frame_start beat, cell beats and a frame_end beat. A
// frame_start gives one status beat; a drawn cell gives eight pixel beats, one
// per cycle from the back end while the output is not stalled; a skipped cell,
// an out-of-range offset and an unknown command leave the front end once the
// job queue has room, and give nothing. Up to QUEUE_DEPTH decided jobs wait
// between front and back end, so input keeps flowing while pixels drain.
// A frame_end copies the 768 frame attributes into the committed store, one
// entry per cycle, and input is stalled while the copy runs.
module spectrum_screen_cell_renderer #(
    parameter int FLASH_PERIOD = 16,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ssr_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ssr_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    logic          job_push;
    ssr_pkg::t_job job;
    logic          q_full;
    logic          q_valid;
    ssr_pkg::t_job q_job;
    logic          q_pop;

    // Front end: classification and shadow stores.
    ssr_front #(.FLASH_PERIOD(FLASH_PERIOD)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job)
    );

    // Job queue.
    ssr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Back end: pixel expansion.
    ssr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_push && q_full))
        else $error("job pushed into a full queue");

    // The last pixel of a cell sits in the rightmost column of the cell.
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_pixel && o_out_item.last) |->
        (o_out_item.pixel_x[2:0] == 3'd7))
        else $error("last pixel beat not in column seven of its cell");

    // A status beat is always the only beat of its frame_start.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.is_pixel) |->
        (o_out_item.last && o_out_item.pixel_x == 8'd0 && o_out_item.color_rgb565 == 16'd0))
        else $error("status beat with pixel content or without last");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the screen cell renderer: random frames, skips and flash.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLASH_PERIOD = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int BEAT_GOAL = 410;
    localparam int SETTLE_CYCLES = 1000;

    // Sixteen-entry RGB565 palette, entry 0 in the lowest 16 bits.
    localparam logic [255:0] RGB_TABLE = {
        16'hFFFF, 16'hFFE0, 16'h07FF, 16'h07E0, 16'hF81F, 16'hF800, 16'h001F, 16'h0000,
        16'hF79E, 16'hF780, 16'h079E, 16'h0780, 16'hF01E, 16'hF000, 16'h001E, 16'h0000
    };

    typedef struct {
        bit                hold_for_drain;
        ssr_pkg::t_in_item beat;
    } t_feed;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    ssr_pkg::t_in_item  i_in_item = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    ssr_pkg::t_out_item o_out_item;

    // Beats waiting to be driven, and pixel/status beats owed by the block.
    t_feed              feed_q[$];
    ssr_pkg::t_out_item render_q[$];
    int                 err_count = 0;

    // Renderer state as seen by the checker.
    logic [7:0]  shown_bmp [ssr_pkg::BMP_DEPTH];
    logic [7:0]  shown_attr [ssr_pkg::ATTR_DEPTH];
    logic [7:0]  frame_attr [ssr_pkg::ATTR_DEPTH];
    bit          cache_ok = 1'b0;
    int unsigned flash_phase = 0;
    bit          flash_inv = 1'b0;

    // What the stimulus planner knows, so that it never reads unwritten entries.
    logic [7:0] plan_pix [ssr_pkg::BMP_DEPTH];
    bit         plan_pix_ok [ssr_pkg::BMP_DEPTH];
    logic [7:0] plan_attr_now [ssr_pkg::ATTR_DEPTH];
    bit         plan_now_ok [ssr_pkg::ATTR_DEPTH];
    logic [7:0] plan_attr_kept [ssr_pkg::ATTR_DEPTH];
    bit         plan_kept_ok [ssr_pkg::ATTR_DEPTH];
    bit         plan_cache_ok = 1'b0;
    int         plan_pool[$];
    int         planned_count = 0;

    // Handshake bookkeeping for the driver and the stall generator.
    logic in_taken = 1'b0;
    int   in_gap = 0;
    bit   in_calm = 1'b0;
    int   stall_left = 0;
    bit   out_calm = 1'b0;

    spectrum_screen_cell_renderer #(.FLASH_PERIOD(FLASH_PERIOD)) uut (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Screen row of a bitmap offset in the interleaved layout.
    function automatic logic [7:0] cell_row(input logic [12:0] off);
        return {off[12:11], off[7:5], off[10:8]};
    endfunction

    // Attribute slot shared by the eight rows of one character cell.
    function automatic logic [9:0] cell_slot(input logic [12:0] off);
        return {off[12:11], off[7:5], off[4:0]};
    endfunction

    // Mostly short idle spans, some medium, a few long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic string beat_text(input ssr_pkg::t_out_item b);
        return $sformatf("redraw=%0d x=%0d y=%0d idx=%0d rgb=%h pix=%0d last=%0d",
                         b.redraw_due, b.pixel_x, b.pixel_y, b.color_index,
                         b.color_rgb565, b.is_pixel, b.last);
    endfunction

    // Works out the beats that one accepted input beat must produce.
    task automatic render_item(input ssr_pkg::t_in_item it);
        logic [7:0]         row;
        logic [9:0]         slot;
        logic [3:0]         ink;
        logic [3:0]         paper;
        logic [3:0]         ci;
        ssr_pkg::t_out_item r;
        case (it.command)
            ssr_pkg::CMD_FRAME_START: begin
                if (it.force_redraw) cache_ok = 1'b0;
                flash_phase++;
                if (flash_phase >= FLASH_PERIOD) begin
                    flash_phase = 0;
                    flash_inv = !flash_inv;
                end
                r = '0;
                r.redraw_due = it.force_redraw || flash_phase == 0 || it.ram_changed;
                r.last = 1'b1;
                render_q.push_back(r);
            end
            ssr_pkg::CMD_CELL: begin
                if (it.cell_offset < ssr_pkg::BMP_LIMIT) begin
                    row = cell_row(it.cell_offset);
                    slot = cell_slot(it.cell_offset);
                    frame_attr[slot] = it.attr_byte;
                    // An unchanged cell stays on screen unless it flashes on a toggle frame.
                    if (!(cache_ok && it.pixel_byte == shown_bmp[it.cell_offset] &&
                          it.attr_byte == shown_attr[slot] &&
                          (flash_phase != 0 || !it.attr_byte[7]))) begin
                        shown_bmp[it.cell_offset] = it.pixel_byte;
                        ink = {1'b0, it.attr_byte[2:0]};
                        paper = {1'b0, it.attr_byte[5:3]};
                        if (it.attr_byte[7] && flash_inv) begin
                            ink = {1'b0, it.attr_byte[5:3]};
                            paper = {1'b0, it.attr_byte[2:0]};
                        end
                        if (it.attr_byte[6]) begin
                            ink = ink + 4'd8;
                            paper = paper + 4'd8;
                        end
                        for (int k = 0; k < 8; k++) begin
                            ci = it.pixel_byte[7-k] ? ink : paper;
                            r = '0;
                            r.pixel_x = {it.cell_offset[4:0], 3'(k)};
                            r.pixel_y = row;
                            r.color_index = ci;
                            r.color_rgb565 = RGB_TABLE[ci*16 +: 16];
                            r.is_pixel = 1'b1;
                            r.last = (k == 7);
                            render_q.push_back(r);
                        end
                    end
                end
            end
            ssr_pkg::CMD_FRAME_END: begin
                shown_attr = frame_attr;
                cache_ok = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Compares one accepted output beat with the oldest owed beat.
    task automatic check_beat(input ssr_pkg::t_out_item got);
        ssr_pkg::t_out_item want;
        if (render_q.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected beat: %s", beat_text(got));
        end else begin
            want = render_q.pop_front();
            if (got.redraw_due !== want.redraw_due || got.pixel_x !== want.pixel_x ||
                got.pixel_y !== want.pixel_y || got.color_index !== want.color_index ||
                got.color_rgb565 !== want.color_rgb565 || got.is_pixel !== want.is_pixel ||
                got.last !== want.last) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("beat mismatch: want %s", beat_text(want));
                    $display("               got  %s", beat_text(got));
                end
            end
        end
    endtask

    function automatic ssr_pkg::t_in_item rand_beat(input logic [1:0] cmd);
        ssr_pkg::t_in_item b;
        b.command = cmd;
        b.cell_offset = 13'($urandom);
        b.pixel_byte = 8'($urandom);
        b.attr_byte = 8'($urandom);
        b.force_redraw = 1'($urandom);
        b.ram_changed = 1'($urandom);
        return b;
    endfunction

    // Queues a beat and tracks which store entries it writes.
    function automatic void plan_beat(input ssr_pkg::t_in_item it, input bit hold);
        t_feed      f;
        logic [9:0] slot;
        case (it.command)
            ssr_pkg::CMD_FRAME_START: begin
                if (it.force_redraw) plan_cache_ok = 1'b0;
                planned_count++;
            end
            ssr_pkg::CMD_CELL: begin
                if (it.cell_offset < ssr_pkg::BMP_LIMIT) begin
                    slot = cell_slot(it.cell_offset);
                    if (!plan_pix_ok[it.cell_offset]) begin
                        plan_pix_ok[it.cell_offset] = 1'b1;
                        plan_pool.push_back(int'(it.cell_offset));
                    end
                    plan_pix[it.cell_offset] = it.pixel_byte;
                    plan_attr_now[slot] = it.attr_byte;
                    plan_now_ok[slot] = 1'b1;
                    planned_count++;
                end
            end
            ssr_pkg::CMD_FRAME_END: begin
                plan_attr_kept = plan_attr_now;
                plan_kept_ok = plan_now_ok;
                plan_cache_ok = 1'b1;
                planned_count++;
            end
            default: ;
        endcase
        f.hold_for_drain = hold;
        f.beat = it;
        feed_q.push_back(f);
    endfunction

    function automatic void plan_cell(input logic [12:0] off, input logic [7:0] pix,
                                      input logic [7:0] attr);
        ssr_pkg::t_in_item b;
        b = rand_beat(ssr_pkg::CMD_CELL);
        b.cell_offset = off;
        b.pixel_byte = pix;
        b.attr_byte = attr;
        plan_beat(b, 1'b0);
    endfunction

    function automatic void plan_start(input bit force_all, input bit changed,
                                       input bit hold);
        ssr_pkg::t_in_item b;
        b = rand_beat(ssr_pkg::CMD_FRAME_START);
        b.force_redraw = force_all;
        b.ram_changed = changed;
        plan_beat(b, hold);
    endfunction

    // An offset whose bitmap byte and committed attribute are both known.
    function automatic int pick_known_offset();
        int off;
        if (plan_pool.size() == 0) return -1;
        for (int t = 0; t < 8; t++) begin
            off = plan_pool[$urandom_range(0, plan_pool.size() - 1)];
            if (plan_kept_ok[cell_slot(13'(off))]) return off;
        end
        return -1;
    endfunction

    // A cell beat that is legal in the current cache state, often a repeat.
    function automatic void plan_random_cell();
        ssr_pkg::t_in_item b;
        int                off;
        logic [9:0]        slot;
        b = rand_beat(ssr_pkg::CMD_CELL);
        if (!plan_cache_ok) begin
            if (plan_pool.size() == 0 || $urandom_range(0, 9) < 7)
                b.cell_offset = 13'($urandom_range(0, ssr_pkg::BMP_DEPTH - 1));
            else
                b.cell_offset = 13'(plan_pool[$urandom_range(0, plan_pool.size() - 1)]);
        end else begin
            off = pick_known_offset();
            if (off < 0) begin
                b.cell_offset = 13'($urandom_range(ssr_pkg::BMP_DEPTH, 8191));
            end else begin
                b.cell_offset = 13'(off);
                slot = cell_slot(b.cell_offset);
                case ($urandom_range(0, 3))
                    0, 1: begin
                        b.pixel_byte = plan_pix[off];
                        b.attr_byte = plan_attr_kept[slot];
                    end
                    2: b.pixel_byte = plan_pix[off];
                    default: b.attr_byte = plan_attr_kept[slot];
                endcase
            end
        end
        plan_beat(b, 1'b0);
    endfunction

    // Input side: sample acceptance; output side: check accepted beats.
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && (o_in_stall === 1'b0);
        if (i_in_valid && (o_in_stall === 1'b0)) render_item(i_in_item);
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) check_beat(o_out_item);
    end

    // Input driver: presents queued beats with random gaps between them.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (feed_q.size() != 0 &&
                         !(feed_q[0].hold_for_drain && render_q.size() != 0)) begin
                i_in_item <= feed_q[0].beat;
                i_in_valid <= 1'b1;
                void'(feed_q.pop_front());
                if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
                in_gap = in_calm ? 0 : pick_idle();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall generator with calm stretches.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
            stall_left = (!out_calm && $urandom_range(0, 3) == 0) ? pick_idle() : 0;
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin
        ssr_pkg::t_in_item b;
        bit                drained;
        bit                hold;
        int                n;

        drained = 1'b0;
        // Cells before any frame, out-of-range offsets and the unused command.
        plan_cell(13'd0, 8'hFF, 8'h00);
        plan_cell(13'd6143, 8'h00, 8'hFF);
        plan_cell(13'h1FFF, 8'hA5, 8'h5A);
        plan_cell(13'd6144, 8'h5A, 8'hA5);
        b = '1;
        b.command = CMD_UNUSED;
        plan_beat(b, 1'b0);
        // A forced frame, then a cached frame with skips and redraws.
        plan_start(1'b1, 1'b1, 1'b0);
        plan_cell(13'h0AAA, 8'h55, 8'h47);
        plan_cell(13'h1555, 8'hAA, 8'hB8);
        plan_beat(rand_beat(ssr_pkg::CMD_FRAME_END), 1'b0);
        plan_start(1'b0, 1'b0, 1'b0);
        plan_cell(13'd0, 8'hFF, 8'h00);
        plan_cell(13'd6143, 8'h00, 8'hFF);
        plan_cell(13'd0, 8'hFE, 8'h00);
        plan_cell(13'h0AAA, 8'h55, 8'h47);
        plan_cell(13'h0AAA, 8'h55, 8'h46);
        plan_beat(rand_beat(ssr_pkg::CMD_FRAME_END), 1'b0);
        plan_start(1'b0, 1'b1, 1'b0);
        plan_start(1'b1, 1'b0, 1'b0);
        plan_cell(13'h0AAA, 8'h00, 8'hC0);
        plan_beat(rand_beat(ssr_pkg::CMD_FRAME_END), 1'b0);

        // Mostly whole frames with random content, some stray beats.
        while (planned_count < BEAT_GOAL) begin
            if ($urandom_range(0, 99) < 85) begin
                hold = (!drained && planned_count >= BEAT_GOAL / 2) ||
                       $urandom_range(0, 49) == 0;
                if (hold) drained = 1'b1;
                plan_start($urandom_range(0, 9) == 0, 1'($urandom), hold);
                n = $urandom_range(0, 12);
                repeat (n) plan_random_cell();
                plan_beat(rand_beat(ssr_pkg::CMD_FRAME_END), 1'b0);
            end else begin
                case ($urandom_range(0, 4))
                    0: plan_beat(rand_beat(CMD_UNUSED), 1'b0);
                    1: begin
                        b = rand_beat(ssr_pkg::CMD_CELL);
                        b.cell_offset = 13'($urandom_range(ssr_pkg::BMP_DEPTH, 8191));
                        plan_beat(b, 1'b0);
                    end
                    2: plan_random_cell();
                    3: plan_start(1'($urandom), 1'($urandom), 1'b0);
                    default: plan_beat(rand_beat(ssr_pkg::CMD_FRAME_END), 1'b0);
                endcase
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (render_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && render_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
